[sv/kvt_pkg.sv]
package kvt_pkg;

    // operation codes (slave-side tuser)
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_FIND   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // result codes (master-side tuser)
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // control part of the request token walking the cell chain
    typedef struct packed {
        logic       active;
        logic [1:0] kind;
        logic       hit;
        logic       free_found;
    } kvt_ctrl_t;

endpackage

[sv/kvt_cell.sv]
module kvt_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IDX_BITS   = 4,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // token from the left neighbor
    input  kvt_pkg::kvt_ctrl_t    in_ctrl,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_wval,
    input  logic [VALUE_BITS-1:0] in_rd,
    input  logic [IDX_BITS-1:0]   in_slot,
    // token to the right neighbor
    output kvt_pkg::kvt_ctrl_t    out_ctrl,
    output logic [KEY_BITS-1:0]   out_key,
    output logic [VALUE_BITS-1:0] out_wval,
    output logic [VALUE_BITS-1:0] out_rd,
    output logic [IDX_BITS-1:0]   out_slot,
    // new-entry write broadcast from the chain end
    input  logic                  commit_en,
    input  logic [IDX_BITS-1:0]   commit_slot,
    input  logic [KEY_BITS-1:0]   commit_key,
    input  logic [VALUE_BITS-1:0] commit_val
);
    import kvt_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

    logic [KEY_BITS-1:0]   entry_key_reg;
    logic [VALUE_BITS-1:0] entry_value_reg;
    logic                  entry_valid_reg;
    logic                  entry_valid_next;

    kvt_ctrl_t             ctrl_reg;
    kvt_ctrl_t             ctrl_next;
    logic [KEY_BITS-1:0]   key_pass_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [VALUE_BITS-1:0] rd_reg;
    logic [VALUE_BITS-1:0] rd_next;
    logic [IDX_BITS-1:0]   slot_reg;
    logic [IDX_BITS-1:0]   slot_next;

    logic match;
    logic take_free;
    logic commit_here;
    logic update_here;

    assign match       = in_ctrl.active && entry_valid_reg && (entry_key_reg == in_key);
    assign take_free   = in_ctrl.active && !entry_valid_reg && !in_ctrl.free_found;
    assign commit_here = commit_en && (commit_slot == MY_IDX);
    assign update_here = match && (in_ctrl.kind == KIND_INSERT);

    always_comb
    begin
        ctrl_next            = in_ctrl;
        ctrl_next.hit        = in_ctrl.hit | match;
        ctrl_next.free_found = in_ctrl.free_found | take_free;
        slot_next            = take_free ? MY_IDX : in_slot;
        rd_next              = (match && in_ctrl.kind == KIND_FIND) ? entry_value_reg : in_rd;
        entry_valid_next     = entry_valid_reg;
        if (commit_here)
        begin
            entry_valid_next = 1'b1;
        end
        else if (match && in_ctrl.kind == KIND_REMOVE)
        begin
            entry_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg        <= '0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg        <= ctrl_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_pass_reg <= in_key;
        wval_reg     <= in_wval;
        rd_reg       <= rd_next;
        slot_reg     <= slot_next;
        if (commit_here)
        begin
            entry_key_reg   <= commit_key;
            entry_value_reg <= commit_val;
        end
        else if (update_here)
        begin
            entry_value_reg <= in_wval;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_key  = key_pass_reg;
    assign out_wval = wval_reg;
    assign out_rd   = rd_reg;
    assign out_slot = slot_reg;

endmodule

[sv/key_value_table.sv]
// key_value_table: associative key/value store built as a row of entry cells.
// Slave side: one transfer per request; tuser carries the operation (insert,
// find, remove), tdata the key and the value to store. Master side: one
// transfer per request; tuser carries the status, tdata the value read by a
// successful find (zero for every other result).
// A request token walks the cell row, one cell per cycle. Each cell compares
// its key, applies update/find/remove on a match and records the first free
// entry. At the end of the row a new insert is written back to the free cell
// by a one-cycle broadcast.
// A result leaves the row end through the holding register into the output
// register that drives m_axis_tvalid. One request is in flight at a time: the
// slave side closes on acceptance and reopens as its result is loaded out.
// Reset clears all valid marks at once; the table is usable right after reset.
// A stalled receiver: the result waits in the output register while the next
// request is accepted and walked; that request's result then parks in a
// holding register and the slave side stays closed until it moves on.
module key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import kvt_pkg::*;

    localparam int IDX_BITS = $clog2(CAPACITY);

    // token chain: index k feeds cell k, index CAPACITY is the row end
    kvt_ctrl_t             ctrl_chain [CAPACITY+1];
    logic [KEY_BITS-1:0]   key_chain  [CAPACITY+1];
    logic [VALUE_BITS-1:0] wval_chain [CAPACITY+1];
    logic [VALUE_BITS-1:0] rd_chain   [CAPACITY+1];
    logic [IDX_BITS-1:0]   slot_chain [CAPACITY+1];
    logic [CAPACITY-1:0]   token_here;

    logic                  in_xfer;
    logic                  commit_en;
    kvt_ctrl_t             end_ctrl;
    logic [2:0]            end_status;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [2:0]            res_status_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [2:0]            out_status_reg;
    logic [31:0]           out_value_reg;
    logic                  out_load;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    // token entering the row
    always_comb
    begin
        ctrl_chain[0]            = '0;
        ctrl_chain[0].active     = in_xfer;
        ctrl_chain[0].kind       = s_axis_tuser;
        ctrl_chain[0].hit        = 1'b0;
        ctrl_chain[0].free_found = 1'b0;
    end
    assign key_chain[0]  = KEY_BITS'(s_axis_tdata[31:0]);
    assign wval_chain[0] = VALUE_BITS'(s_axis_tdata[63:32]);
    assign rd_chain[0]   = '0;
    assign slot_chain[0] = '0;

    assign end_ctrl  = ctrl_chain[CAPACITY];
    assign commit_en = end_ctrl.active && (end_ctrl.kind == KIND_INSERT)
                       && !end_ctrl.hit && end_ctrl.free_found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        kvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .IDX_BITS   (IDX_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_ctrl     (ctrl_chain[i]),
            .in_key      (key_chain[i]),
            .in_wval     (wval_chain[i]),
            .in_rd       (rd_chain[i]),
            .in_slot     (slot_chain[i]),
            .out_ctrl    (ctrl_chain[i+1]),
            .out_key     (key_chain[i+1]),
            .out_wval    (wval_chain[i+1]),
            .out_rd      (rd_chain[i+1]),
            .out_slot    (slot_chain[i+1]),
            .commit_en   (commit_en),
            .commit_slot (slot_chain[CAPACITY]),
            .commit_key  (key_chain[CAPACITY]),
            .commit_val  (wval_chain[CAPACITY])
        );
        assign token_here[i] = ctrl_chain[i+1].active;
    end

    // status decode at the row end
    always_comb
    begin
        case (end_ctrl.kind)
            KIND_INSERT:
            begin
                if (end_ctrl.hit)
                    end_status = ST_UPDATED;
                else if (end_ctrl.free_found)
                    end_status = ST_INSERTED;
                else
                    end_status = ST_FULL;
            end
            KIND_FIND:   end_status = end_ctrl.hit ? ST_FOUND : ST_NOT_FOUND;
            KIND_REMOVE: end_status = end_ctrl.hit ? ST_REMOVED : ST_NOT_FOUND;
            default:     end_status = ST_NOT_FOUND;
        endcase
    end

    // holding register -> output register
    assign out_load = res_valid_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer)
            busy_next = 1'b1;
        if (end_ctrl.active)
            res_valid_next = 1'b1;
        if (out_load)
        begin
            res_valid_next = 1'b0;
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_ctrl.active)
        begin
            res_status_reg <= end_status;
            res_value_reg  <= rd_chain[CAPACITY];
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= 32'(res_value_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // only one request token is ever in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(token_here) <= 1)
        else $error("more than one token in the cell row");

    // a token in the row always belongs to an accepted request
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (token_here != '0) |-> busy_reg)
        else $error("token in the row while idle");

    // the holding register is empty when a token reaches the row end
    a_hold_free: assert property (@(posedge clk) disable iff (!rst_n)
        end_ctrl.active |-> !res_valid_reg)
        else $error("result overrun at the row end");

    // an insert of a new key is committed only with a free entry in hand
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit_en |=> (res_valid_reg && res_status_reg == ST_INSERTED))
        else $error("commit without inserted status");

endmodule

[test/key_value_table_test.sv]
module key_value_table_test;

    import kvt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;    // more keys than entries, so the table fills up
    localparam int BURST_ITEMS = 550;   // random requests per idling phase
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off

    // kind 3 has no operation behind it; the block must answer not found
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
    } kv_result_t;

    // Mirror of the table contents plus the queue of answers still owed by the block.
    class kv_scoreboard;
        logic [31:0] stored_key   [TABLE_DEPTH];
        logic [31:0] stored_value [TABLE_DEPTH];
        bit          occupied     [TABLE_DEPTH];
        kv_result_t  awaited [$];
        int unsigned errors;
        int unsigned requests;
        int unsigned status_count [8];

        // One accepted request: apply it to the mirror and queue its answer.
        function void note_request(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
            int         hit;
            int         slot;
            int         i;
            kv_result_t res;
            hit  = -1;
            slot = -1;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (occupied[i] && stored_key[i] == key && hit < 0)
                    hit = i;
                if (!occupied[i] && slot < 0)
                    slot = i;
            end
            res.status     = ST_NOT_FOUND;
            res.read_value = '0;
            case (kind)
                KIND_INSERT:
                begin
                    if (hit >= 0)
                    begin
                        stored_value[hit] = value;
                        res.status = ST_UPDATED;
                    end
                    else if (slot >= 0)
                    begin
                        stored_key[slot]   = key;
                        stored_value[slot] = value;
                        occupied[slot]     = 1'b1;
                        res.status = ST_INSERTED;
                    end
                    else
                        res.status = ST_FULL;
                end
                KIND_FIND:
                begin
                    if (hit >= 0)
                    begin
                        res.status     = ST_FOUND;
                        res.read_value = stored_value[hit];
                    end
                end
                KIND_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        occupied[hit] = 1'b0;
                        res.status = ST_REMOVED;
                    end
                end
                default:
                    ;
            endcase
            requests++;
            awaited.push_back(res);
        endfunction

        // One accepted result: compare with the oldest owed answer.
        function void check_result(logic [2:0] status, logic [31:0] read_value);
            kv_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing owed: status %0d value %h",
                         $time, status, read_value);
                errors++;
                return;
            end
            want = awaited.pop_front();
            status_count[want.status]++;
            if (status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (read_value !== want.read_value)
            begin
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, want.read_value, read_value);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] lookup_key, [63:32] write_value
    logic [1:0]  s_axis_tuser;     // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] read_value
    logic [2:0]  m_axis_tuser;     // [2:0] status

    kv_scoreboard board;

    // idling odds in percent, changed per phase by the main sequence
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // main sequence raises hold_request; the receiver process counts the hold itself
    bit          hold_request;
    int unsigned hold_left;

    logic [31:0] key_pool [POOL_SIZE];

    key_value_table #(
        .CAPACITY   (TABLE_DEPTH),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs on either side.
    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d results still owed", $time, board.pending());
        $display("key_value_table verification failed");
        $finish;
    end

    // Monitor: both handshakes sampled at the rising edge. The request is
    // noted before any result of the same edge is checked; a result never
    // belongs to a request accepted on the same edge, so the order is moot.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // Receiver: tready changes on the falling edge only. A hold request
    // drops tready while hold_left counts down, so the result and holding
    // registers fill and the slave side has to close.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request; called and returns at a falling edge. tvalid is
    // left high on return so a back-to-back request keeps it up without a
    // second assignment in the same step.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                                input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Edges of the key and value space, every operation, the spare code,
    // absent keys, a table filled to the last entry and an insert past it.
    task automatic run_directed();
        int i;
        send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);   // update in place
        send_request(KIND_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_FIND,   32'h1234_5678, 32'h0000_0000);   // absent key
        send_request(KIND_REMOVE, 32'h1234_5678, 32'h0000_0000);   // absent key
        send_request(KIND_SPARE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_FIND,   32'h0000_0000, 32'h0000_0000);
        // one entry taken by the all-ones key: fill the other fifteen
        for (i = 0; i < TABLE_DEPTH - 1; i++)
            send_request(KIND_INSERT, 32'h0000_0001 << i, ~(32'h0000_0001 << i));
        send_request(KIND_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);   // table full
        send_request(KIND_FIND,   32'h0000_4000, 32'h0000_0000);
    endtask

    // Mostly keys from a small pool so that updates, hits and removes are
    // common and the table often runs full; some fully random keys as noise.
    task automatic run_random(input int count);
        int          n;
        int unsigned pick;
        logic [1:0]  kind;
        logic [31:0] key;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                kind = KIND_INSERT;
            else if (pick < 70)
                kind = KIND_FIND;
            else if (pick < 95)
                kind = KIND_REMOVE;
            else
                kind = KIND_SPARE;
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                key = $urandom;
            send_request(kind, key, $urandom);
        end
    endtask

    initial
    begin
        int i;
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INSERT;
        send_idle_pct = 31;
        recv_idle_pct = 60;
        hold_request  = 1'b0;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // phase 1: sender idles 31%, receiver 60%
        run_directed();
        run_random(BURST_ITEMS);

        // phase 2: roles swapped
        send_idle_pct = 60;
        recv_idle_pct = 31;
        run_random(BURST_ITEMS);

        // phase 3: no idling, opened by a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        run_random(BURST_ITEMS);
        s_axis_tvalid <= 1'b0;

        // drain, then give a stray late result time to show up
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge clk);

        $display("ran %0d requests through three idling phases and a long receiver stall",
                 board.requests);
        $display("answers: %0d inserted, %0d updated, %0d found, %0d absent, %0d removed, %0d full",
                 board.status_count[ST_INSERTED], board.status_count[ST_UPDATED],
                 board.status_count[ST_FOUND], board.status_count[ST_NOT_FOUND],
                 board.status_count[ST_REMOVED], board.status_count[ST_FULL]);
        if (board.errors == 0 && board.pending() == 0)
            $display("key_value_table verification clean");
        else
            $display("key_value_table verification failed");
        $finish;
    end

endmodule
